>>> hdl/decimal_number_literal_validator_defines.svh
// assertion macros used by the checker file
`ifndef DECIMAL_NUMBER_LITERAL_VALIDATOR_DEFINES_SVH
`define DECIMAL_NUMBER_LITERAL_VALIDATOR_DEFINES_SVH

// same-cycle implication
`define DNLV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DNLV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/dnlv_pkg.sv
// types and character constants of the decimal literal validator
package dnlv_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_EXP   = 8'h65;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [2:0] {
      CLS_NONE  = 3'd0,
      CLS_SPACE = 3'd1,
      CLS_SIGN  = 3'd2,
      CLS_DIGIT = 3'd3,
      CLS_DOT   = 3'd4,
      CLS_EXP   = 3'd5,
      CLS_OTHER = 3'd6
   } dnlv_class_type;

   typedef struct packed {
      dnlv_class_type cls;
      logic           last;
   } dnlv_item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } dnlv_q_status_type;

   typedef enum logic [9:0] {
      ST_LEAD     = 10'b00_0000_0001,
      ST_SIGN     = 10'b00_0000_0010,
      ST_INT      = 10'b00_0000_0100,
      ST_DOT_BARE = 10'b00_0000_1000,
      ST_FRAC     = 10'b00_0001_0000,
      ST_EXP      = 10'b00_0010_0000,
      ST_EXP_SIGN = 10'b00_0100_0000,
      ST_EXP_DIG  = 10'b00_1000_0000,
      ST_TRAIL    = 10'b01_0000_0000,
      ST_ERR      = 10'b10_0000_0000
   } dnlv_state_type;

endpackage

>>> hdl/dnlv_front.sv
// request intake and character classification
module dnlv_front (
   input  logic                       req_valid,
   input  logic [7:0]                 req_ch,
   input  logic                       req_ch_present,
   input  logic                       req_last,
   output logic                       req_stall,
   input  dnlv_pkg::dnlv_q_status_type q_status,
   output logic                       push,
   output dnlv_pkg::dnlv_item_type    push_item
);
   import dnlv_pkg::*;

   function automatic dnlv_class_type classify(input logic present, input logic [7:0] c);
      dnlv_class_type cls;
      if (!present) begin
         cls = CLS_NONE;
      end else if (c == CHAR_SPACE) begin
         cls = CLS_SPACE;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         cls = CLS_SIGN;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         cls = CLS_DIGIT;
      end else if (c == CHAR_DOT) begin
         cls = CLS_DOT;
      end else if (c == CHAR_EXP) begin
         cls = CLS_EXP;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

   assign req_stall      = q_status.full;
   assign push           = req_valid && !q_status.full;
   assign push_item.cls  = classify(req_ch_present, req_ch);
   assign push_item.last = req_last;

endmodule

>>> hdl/dnlv_queue.sv
// two-entry queue of classified requests
module dnlv_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  dnlv_pkg::dnlv_item_type     push_item,
   input  logic                        pop,
   output dnlv_pkg::dnlv_item_type     pop_item,
   output dnlv_pkg::dnlv_q_status_type q_status
);
   import dnlv_pkg::*;

   dnlv_item_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                       do_push, do_pop;

   assign q_status.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.not_empty = (count_ff != '0);
   assign do_push            = push && !q_status.full;
   assign do_pop             = pop && q_status.not_empty;
   assign pop_item           = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hdl/dnlv_back.sv
// parse state machine and result register
module dnlv_back (
   input  logic                        clock,
   input  logic                        reset,
   input  dnlv_pkg::dnlv_q_status_type q_status,
   input  dnlv_pkg::dnlv_item_type     pop_item,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic                        rsp_is_number,
   input  logic                        rsp_stall
);
   import dnlv_pkg::*;

   dnlv_state_type state_ff, state_in, state_nx;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_is_number_ff, rsp_is_number_in;
   logic           out_free;

   function automatic dnlv_state_type next_state(input dnlv_state_type st,
                                                 input dnlv_class_type cls);
      dnlv_state_type nx;
      nx = ST_ERR;
      if (cls == CLS_NONE) begin
         nx = st;
      end else begin
         unique case (st)
            ST_LEAD: begin
               case (cls)
                  CLS_SPACE: nx = ST_LEAD;
                  CLS_SIGN:  nx = ST_SIGN;
                  CLS_DIGIT: nx = ST_INT;
                  CLS_DOT:   nx = ST_DOT_BARE;
                  default:   nx = ST_ERR;
               endcase
            end
            ST_SIGN: begin
               case (cls)
                  CLS_DIGIT: nx = ST_INT;
                  CLS_DOT:   nx = ST_DOT_BARE;
                  default:   nx = ST_ERR;
               endcase
            end
            ST_INT: begin
               case (cls)
                  CLS_DIGIT: nx = ST_INT;
                  CLS_DOT:   nx = ST_FRAC;
                  CLS_EXP:   nx = ST_EXP;
                  CLS_SPACE: nx = ST_TRAIL;
                  default:   nx = ST_ERR;
               endcase
            end
            ST_DOT_BARE: nx = (cls == CLS_DIGIT) ? ST_FRAC : ST_ERR;
            ST_FRAC: begin
               case (cls)
                  CLS_DIGIT: nx = ST_FRAC;
                  CLS_EXP:   nx = ST_EXP;
                  CLS_SPACE: nx = ST_TRAIL;
                  default:   nx = ST_ERR;
               endcase
            end
            ST_EXP: begin
               case (cls)
                  CLS_SIGN:  nx = ST_EXP_SIGN;
                  CLS_DIGIT: nx = ST_EXP_DIG;
                  default:   nx = ST_ERR;
               endcase
            end
            ST_EXP_SIGN: nx = (cls == CLS_DIGIT) ? ST_EXP_DIG : ST_ERR;
            ST_EXP_DIG: begin
               case (cls)
                  CLS_DIGIT: nx = ST_EXP_DIG;
                  CLS_SPACE: nx = ST_TRAIL;
                  default:   nx = ST_ERR;
               endcase
            end
            ST_TRAIL: nx = (cls == CLS_SPACE) ? ST_TRAIL : ST_ERR;
            ST_ERR:   nx = ST_ERR;
            default:  nx = ST_ERR;
         endcase
      end
      return nx;
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = q_status.not_empty && (!pop_item.last || out_free);
   assign state_nx = next_state(state_ff, pop_item.cls);

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_is_number_in = rsp_is_number_ff;
      if (pop) begin
         if (pop_item.last) begin
            state_in         = ST_LEAD;
            rsp_valid_in     = 1'b1;
            rsp_is_number_in = (state_nx == ST_INT) || (state_nx == ST_FRAC) ||
                               (state_nx == ST_EXP_DIG) || (state_nx == ST_TRAIL);
         end else begin
            state_in = state_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LEAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_is_number_ff <= rsp_is_number_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_number = rsp_is_number_ff;

endmodule

>>> hdl/decimal_number_literal_validator.sv
// top level of the decimal number literal validator
// Takes one request per cycle, sustained, as long as the result side keeps up: each byte
// gets a class check on the way into a two-entry queue and one state step when it leaves it.
// The verdict for a string is held in a result register, written when its last request
// leaves the queue; a stalled result still lets non-last bytes and one or two further
// requests flow in, until the queue is full.
module decimal_number_literal_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_ch_present,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_number
);
   import dnlv_pkg::*;

   dnlv_q_status_type q_status;
   dnlv_item_type     push_item, pop_item;
   logic              push, pop;

   dnlv_front u_front (
      .req_valid      (req_valid),
      .req_ch         (req_ch),
      .req_ch_present (req_ch_present),
      .req_last       (req_last),
      .req_stall      (req_stall),
      .q_status       (q_status),
      .push           (push),
      .push_item      (push_item)
   );

   dnlv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   dnlv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .pop_item      (pop_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_is_number (rsp_is_number),
      .rsp_stall     (rsp_stall)
   );

endmodule

>>> hdl/dnlv_checker.sv
// port-level checks of the validator and their binding
`include "decimal_number_literal_validator_defines.svh"

module dnlv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_is_number
);
   logic [2:0] pending_ff, pending_in;
   logic       last_in, rsp_out;

   assign last_in    = req_valid && !req_stall && req_last;
   assign rsp_out    = rsp_valid && !rsp_stall;
   assign pending_in = pending_ff + 3'(last_in) - 3'(rsp_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `DNLV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_is_number), "stalled result changed")
   `DNLV_ASSERT_IMPL(a_rsp_owed, clock, reset, rsp_valid, pending_ff != 3'd0, "result without a last request")
   `DNLV_ASSERT_IMPL(a_pending_cap, clock, reset, 1'b1, pending_ff <= 3'd3, "too many strings in flight")
   `DNLV_ASSERT_NEXT(a_full_stall, clock, reset, pending_ff == 3'd3 && rsp_stall && rsp_valid, req_stall || !req_last || !req_valid || rsp_out, "last request taken with no room")

endmodule

bind decimal_number_literal_validator dnlv_checker u_checker (.*);

>>> bench/decimal_number_literal_validator_tb.sv
// self-checking testbench of the decimal number literal validator
`timescale 1ns / 100ps

module decimal_number_literal_validator_tb;
   import dnlv_pkg::*;

   localparam logic [7:0] CHAR_UPPER_E = 8'h45;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 180;

   typedef logic [7:0] text_type[$];

   class literal_scoreboard;
      dnlv_state_type parse_st;
      bit verdicts[$];
      int errors;

      function new();
         parse_st = ST_LEAD;
         errors = 0;
      endfunction

      function dnlv_state_type next_parse(dnlv_state_type st, logic [7:0] c);
         bit dig;
         bit sp;
         bit dot;
         bit ex;
         bit sgn;
         dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         sp = (c == CHAR_SPACE);
         dot = (c == CHAR_DOT);
         ex = (c == CHAR_EXP);
         sgn = (c == CHAR_PLUS) || (c == CHAR_MINUS);
         next_parse = ST_ERR;
         case (st)
            ST_LEAD: begin
               if (sp) next_parse = ST_LEAD;
               else if (sgn) next_parse = ST_SIGN;
               else if (dig) next_parse = ST_INT;
               else if (dot) next_parse = ST_DOT_BARE;
            end
            ST_SIGN: begin
               if (dig) next_parse = ST_INT;
               else if (dot) next_parse = ST_DOT_BARE;
            end
            ST_INT: begin
               if (dig) next_parse = ST_INT;
               else if (dot) next_parse = ST_FRAC;
               else if (ex) next_parse = ST_EXP;
               else if (sp) next_parse = ST_TRAIL;
            end
            ST_DOT_BARE: begin
               if (dig) next_parse = ST_FRAC;
            end
            ST_FRAC: begin
               if (dig) next_parse = ST_FRAC;
               else if (ex) next_parse = ST_EXP;
               else if (sp) next_parse = ST_TRAIL;
            end
            ST_EXP: begin
               if (sgn) next_parse = ST_EXP_SIGN;
               else if (dig) next_parse = ST_EXP_DIG;
            end
            ST_EXP_SIGN: begin
               if (dig) next_parse = ST_EXP_DIG;
            end
            ST_EXP_DIG: begin
               if (dig) next_parse = ST_EXP_DIG;
               else if (sp) next_parse = ST_TRAIL;
            end
            ST_TRAIL: begin
               if (sp) next_parse = ST_TRAIL;
            end
            default: next_parse = ST_ERR;
         endcase
      endfunction

      function void note_request(logic [7:0] c, logic present, logic last);
         if (present) parse_st = next_parse(parse_st, c);
         if (last) begin
            verdicts.push_back(parse_st == ST_INT || parse_st == ST_FRAC ||
                               parse_st == ST_EXP_DIG || parse_st == ST_TRAIL);
            parse_st = ST_LEAD;
         end
      endfunction

      function void check_result(logic actual);
         bit want;
         if (verdicts.size() == 0) begin
            $display("%0t: unexpected result, is_number got %b", $time, actual);
            errors++;
         end else begin
            want = verdicts.pop_front();
            if (actual !== want) begin
               $display("%0t: is_number expected %b, got %b", $time, want, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return verdicts.size();
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch = 8'h00;
   logic       req_ch_present = 1'b0;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_is_number;

   literal_scoreboard sb;
   int req_idle_pct = 30;
   int rsp_stall_pct = 59;
   int items_sent = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_off_req = 1'b0;
   bit took;

   decimal_number_literal_validator u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .req_ch_present (req_ch_present),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_number  (rsp_is_number)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side: random stall, or a long hold-off on demand
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_left = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         took = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_is_number);
            took = 1'b1;
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_ch, req_ch_present, req_last);
            took = 1'b1;
         end
         if (took) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("decimal_number_literal_validator verification failed");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [7:0] c, input logic present, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_ch_present <= present;
      req_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (present || last) items_sent++;
   endtask

   task automatic send_text(input text_type t);
      bit end_marker;
      end_marker = (t.size() == 0) || ($urandom_range(3) == 0);
      foreach (t[i]) begin
         // stray request with no character inside the string
         if ($urandom_range(19) == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
         send_request(t[i], 1'b1, !end_marker && (i == t.size() - 1));
      end
      if (end_marker) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   function automatic text_type to_text(string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(7))
         0: pick_char = CHAR_SPACE;
         1: pick_char = CHAR_EXP;
         2: pick_char = CHAR_DOT;
         3: pick_char = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
         4: pick_char = CHAR_ZERO + 8'($urandom_range(9));
         5: pick_char = CHAR_UPPER_E;
         default: pick_char = 8'($urandom_range(255));
      endcase
   endfunction

   function automatic text_type make_literal();
      text_type t;
      int form;
      form = $urandom_range(3);
      if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) t.push_back(CHAR_SPACE);
      case ($urandom_range(2))
         1: t.push_back(CHAR_PLUS);
         2: t.push_back(CHAR_MINUS);
         default: ;
      endcase
      // integer only, integer point, point fraction, integer point fraction
      if (form != 2) repeat ($urandom_range(1, 4)) t.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      if (form != 0) t.push_back(CHAR_DOT);
      if (form >= 2) repeat ($urandom_range(1, 4)) t.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(2) == 0) begin
         t.push_back(CHAR_EXP);
         case ($urandom_range(2))
            1: t.push_back(CHAR_PLUS);
            2: t.push_back(CHAR_MINUS);
            default: ;
         endcase
         repeat ($urandom_range(1, 3)) t.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      end
      if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) t.push_back(CHAR_SPACE);
      return t;
   endfunction

   function automatic text_type mutate(text_type t);
      int k;
      k = $urandom_range(t.size());
      if (k == t.size() || $urandom_range(2) == 0) begin
         t.insert(k, pick_char());
      end else if ($urandom_range(1)) begin
         t[k] = pick_char();
      end else begin
         t.delete(k);
      end
      return t;
   endfunction

   function automatic text_type make_noise();
      text_type t;
      repeat ($urandom_range(1, 6)) t.push_back(pick_char());
      return t;
   endfunction

   task automatic run_random(input int n_items, input bit with_hold);
      int stop_at;
      int r;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if (with_hold && items_sent > stop_at - n_items / 2) begin
            hold_off_req = 1'b1;
            with_hold = 1'b0;
         end
         r = $urandom_range(99);
         if (r < 70) send_text(make_literal());
         else if (r < 85) send_text(mutate(make_literal()));
         else if (r < 95) send_text(make_noise());
         else if (r < 97) send_text(to_text(""));
         else send_text(to_text("  "));
      end
   endtask

   initial begin
      sb = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed strings
      send_text(to_text(""));
      send_text(to_text("   "));
      send_text(to_text(" -9.e+0 "));
      send_text(to_text("+.5"));
      send_text(to_text("1E5"));
      send_text(to_text(".e1"));
      send_text(to_text("4 4"));
      send_request(CHAR_ZERO + 8'd3, 1'b1, 1'b0);
      send_request(8'hff, 1'b0, 1'b0);
      send_request(CHAR_EXP, 1'b1, 1'b0);
      send_request(CHAR_ZERO + 8'd2, 1'b1, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);

      run_random(PHASE_ITEMS, 1'b1);
      req_idle_pct = 59;
      rsp_stall_pct = 30;
      run_random(PHASE_ITEMS, 1'b0);
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random(PHASE_ITEMS, 1'b1);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("decimal_number_literal_validator verification clean");
      end else begin
         $display("decimal_number_literal_validator verification failed");
      end
      $finish;
   end

endmodule
